// ===== src/xsrng_pkg.sv =====
package xsrng_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CntW  = $clog2(WordW);

  // splitmix64 constants
  localparam logic [WordW-1:0] SmGamma = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] SmMul1  = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] SmMul2  = 64'h94d049bb133111eb;

  // request codes
  localparam logic [1:0] FuncSeed    = 2'd0;
  localparam logic [1:0] FuncRaw     = 2'd1;
  localparam logic [1:0] FuncBounded = 2'd2;
  localparam logic [1:0] FuncNop     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgDefaultSeed = 2'd0;
  localparam logic [1:0] CfgLowerBound  = 2'd1;
  localparam logic [1:0] CfgUpperBound  = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [WordW-1:0] seed_value;
  } in_word_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MUL1,
    ST_MUL2,
    ST_DRAW,
    ST_POST,
    ST_MOD,
    ST_FIN
  } state_e;

endpackage

// ===== src/xsrng_mul.sv =====
// Bit-serial multiplier, low word of the product. One multiplier bit per cycle.
module xsrng_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [xsrng_pkg::WordW-1:0]  a_i,
  input  logic [xsrng_pkg::WordW-1:0]  b_i,
  output logic                         done_o,
  output logic [xsrng_pkg::WordW-1:0]  prod_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [xsrng_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [xsrng_pkg::WordW-1:0] a_q, a_d;
  logic [xsrng_pkg::WordW-1:0] b_q, b_d;
  logic [xsrng_pkg::WordW-1:0] acc_q, acc_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == xsrng_pkg::CntW'(xsrng_pkg::WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== src/xsrng_mod.sv =====
// Restoring remainder, one dividend bit per cycle. Divisor must be nonzero.
module xsrng_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [xsrng_pkg::WordW-1:0]  dividend_i,
  input  logic [xsrng_pkg::WordW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [xsrng_pkg::WordW-1:0]  rem_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [xsrng_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [xsrng_pkg::WordW-1:0] dvd_q, dvd_d;
  logic [xsrng_pkg::WordW-1:0] dvs_q, dvs_d;
  logic [xsrng_pkg::WordW-1:0] rem_q, rem_d;
  logic [xsrng_pkg::WordW:0]   shifted;
  logic [xsrng_pkg::WordW:0]   diff;

  assign shifted = {rem_q, dvd_q[xsrng_pkg::WordW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // no borrow: shifted value reaches the divisor
      if (!diff[xsrng_pkg::WordW]) begin
        rem_d = diff[xsrng_pkg::WordW-1:0];
      end else begin
        rem_d = shifted[xsrng_pkg::WordW-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == xsrng_pkg::CntW'(xsrng_pkg::WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/xorshift128plus_bounded_rng_core.sv =====
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall  func, seed_value
// out       output     out_valid/ out_stall value, status
// cfg       input      cfg_valid/ cfg_ready index (0 seed, 1 lower, 2 upper), data
//
// One request at a time. Raw draw: after accept, DRAW, POST and FIN lead to the registered result.
// Bounded draw: the result waits on the bit-serial remainder unit (64 steps).
// Seeding (reseed, or first draw) runs MIX, MUL1 and MUL2 twice, on the
// bit-serial multiplier that runs four 64-step products.
// Reset leaves the generator unseeded; cfg regs go to 0, 0, 1.
// The output register lets a new request start while a result waits on stall.
module xorshift128plus_bounded_rng_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  xsrng_pkg::in_word_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output xsrng_pkg::out_word_t         out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [xsrng_pkg::WordW-1:0]  cfg_data_i
);

  localparam int unsigned W = xsrng_pkg::WordW;

  xsrng_pkg::state_e    state_q, state_d;
  logic [1:0]           func_q, func_d;
  logic                 half_q, half_d;      // 0: filling word a, 1: word b
  logic                 seeded_q, seeded_d;
  logic [W-1:0]         acc_q, acc_d;        // splitmix64 counter
  logic [W-1:0]         word_a_q, word_a_d;
  logic [W-1:0]         word_b_q, word_b_d;
  xsrng_pkg::out_word_t res_q, res_d;
  xsrng_pkg::out_word_t out_data_q, out_data_d;
  logic                 out_valid_q, out_valid_d;

  // configuration registers
  logic [W-1:0]         dflt_seed_q;
  logic [W-1:0]         lower_q;
  logic [W-1:0]         upper_q;

  // serial units
  logic                 mul_start;
  logic [W-1:0]         mul_a;
  logic [W-1:0]         mul_b;
  logic                 mul_done;
  logic [W-1:0]         mul_prod;
  logic                 mod_start;
  logic [W-1:0]         mod_dvd;
  logic                 mod_done;
  logic [W-1:0]         mod_rem;

  logic                 in_fire;
  logic                 out_fire;
  logic                 bad_range;
  logic [W-1:0]         mix_sum;
  logic [W-1:0]         xs_x;
  logic [W-1:0]         mix_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != xsrng_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign bad_range   = ($signed(lower_q) >= $signed(upper_q));

  assign mix_sum = acc_q + xsrng_pkg::SmGamma;
  assign mix_out = mul_prod ^ (mul_prod >> 31);
  assign xs_x    = word_a_q ^ (word_a_q << 23);
  assign mod_dvd = word_b_q + word_a_q;   // raw draw after the state update

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    half_d      = half_q;
    seeded_d    = seeded_q;
    acc_d       = acc_q;
    word_a_d    = word_a_q;
    word_b_d    = word_b_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    mul_start   = 1'b0;
    mul_a       = mix_sum ^ (mix_sum >> 30);
    mul_b       = xsrng_pkg::SmMul1;
    mod_start   = 1'b0;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      xsrng_pkg::ST_IDLE: begin
        if (in_fire) begin
          func_d = in_data_i.func;
          half_d = 1'b0;
          res_d  = '0;
          case (in_data_i.func)
            xsrng_pkg::FuncSeed: begin
              acc_d   = in_data_i.seed_value;
              state_d = xsrng_pkg::ST_MIX;
            end
            xsrng_pkg::FuncRaw, xsrng_pkg::FuncBounded: begin
              if (in_data_i.func == xsrng_pkg::FuncBounded && bad_range) begin
                // rejected: no advance, no auto-seed
                res_d.status = 1'b1;
                state_d      = xsrng_pkg::ST_FIN;
              end else if (seeded_q) begin
                state_d = xsrng_pkg::ST_DRAW;
              end else begin
                acc_d   = dflt_seed_q;
                state_d = xsrng_pkg::ST_MIX;
              end
            end
            default: begin
              state_d = xsrng_pkg::ST_FIN;
            end
          endcase
        end
      end
      xsrng_pkg::ST_MIX: begin
        acc_d     = mix_sum;
        mul_start = 1'b1;
        state_d   = xsrng_pkg::ST_MUL1;
      end
      xsrng_pkg::ST_MUL1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod ^ (mul_prod >> 27);
          mul_b     = xsrng_pkg::SmMul2;
          state_d   = xsrng_pkg::ST_MUL2;
        end
      end
      xsrng_pkg::ST_MUL2: begin
        if (mul_done) begin
          if (!half_q) begin
            word_a_d = mix_out;
            half_d   = 1'b1;
            state_d  = xsrng_pkg::ST_MIX;
          end else begin
            word_b_d = mix_out;
            seeded_d = 1'b1;
            if (func_q == xsrng_pkg::FuncSeed) begin
              state_d = xsrng_pkg::ST_FIN;
            end else begin
              state_d = xsrng_pkg::ST_DRAW;
            end
          end
        end
      end
      xsrng_pkg::ST_DRAW: begin
        // xorshift128+ step: 23 / 17 / 26
        word_a_d = word_b_q;
        word_b_d = xs_x ^ word_b_q ^ (xs_x >> 17) ^ (word_b_q >> 26);
        state_d  = xsrng_pkg::ST_POST;
      end
      xsrng_pkg::ST_POST: begin
        if (func_q == xsrng_pkg::FuncRaw) begin
          res_d.value = mod_dvd;
          state_d     = xsrng_pkg::ST_FIN;
        end else begin
          mod_start = 1'b1;
          state_d   = xsrng_pkg::ST_MOD;
        end
      end
      xsrng_pkg::ST_MOD: begin
        if (mod_done) begin
          res_d.value = lower_q + mod_rem;
          state_d     = xsrng_pkg::ST_FIN;
        end
      end
      xsrng_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = xsrng_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = xsrng_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xsrng_pkg::ST_IDLE;
      func_q      <= xsrng_pkg::FuncNop;
      half_q      <= 1'b0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      word_a_q    <= '0;
      word_b_q    <= '0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      half_q      <= half_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      word_a_q    <= word_a_d;
      word_b_q    <= word_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_seed_q <= '0;
      lower_q     <= '0;
      upper_q     <= W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        xsrng_pkg::CfgDefaultSeed: dflt_seed_q <= cfg_data_i;
        xsrng_pkg::CfgLowerBound:  lower_q     <= cfg_data_i;
        xsrng_pkg::CfgUpperBound:  upper_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  xsrng_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  xsrng_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (upper_q - lower_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WordW = xsrng_pkg::WordW;

  // splitmix64 / xorshift128+ constants, kept local so the predictor stands on its own
  localparam logic [WordW-1:0] MixGamma = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMulA  = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMulB  = 64'h94d049bb133111eb;

  localparam logic [WordW-1:0] AllOnes = '1;
  localparam logic [WordW-1:0] MinS    = 64'h8000_0000_0000_0000;
  localparam logic [WordW-1:0] MaxS    = 64'h7fff_ffff_ffff_ffff;

  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseWords = 172;
  // long enough for a full seeding plus a bounded draw
  localparam int unsigned TailCycles = 400;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  xsrng_pkg::in_word_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  xsrng_pkg::out_word_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [WordW-1:0]     cfg_data  = '0;

  xorshift128plus_bounded_rng_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Requests waiting to be sent, and the result words the generator owes us.
  xsrng_pkg::in_word_t  requests_q[$];
  xsrng_pkg::out_word_t draws_owed_q[$];

  // Per-phase idling, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // Set at the edge that takes the request, cleared by the driver.
  bit in_taken = 1'b0;

  int unsigned errors = 0;
  int unsigned n_reseed = 0, n_raw = 0, n_bounded = 0, n_reject = 0, n_nop = 0;
  int unsigned n_cfg = 0;

  // Predictor copy of the generator and its registers (reset values).
  logic [WordW-1:0] cfg_seed   = '0;
  logic [WordW-1:0] cfg_lo     = '0;
  logic [WordW-1:0] cfg_hi     = 64'd1;
  logic [WordW-1:0] gen_a      = '0;
  logic [WordW-1:0] gen_b      = '0;
  bit               gen_seeded = 1'b0;

  // One splitmix64 output from an already advanced accumulator.
  function automatic logic [WordW-1:0] splitmix_out(input logic [WordW-1:0] acc);
    logic [WordW-1:0] z;
    z = acc;
    z = (z ^ (z >> 30)) * MixMulA;
    z = (z ^ (z >> 27)) * MixMulB;
    return z ^ (z >> 31);
  endfunction

  task automatic seed_gen(input logic [WordW-1:0] seed);
    gen_a      = splitmix_out(seed + MixGamma);
    gen_b      = splitmix_out(seed + MixGamma + MixGamma);
    gen_seeded = 1'b1;
  endtask

  // xorshift128+ step; seeds from the default seed on first use.
  task automatic draw_gen(output logic [WordW-1:0] sum);
    logic [WordW-1:0] x, y;
    if (!gen_seeded) seed_gen(cfg_seed);
    x     = gen_a;
    y     = gen_b;
    gen_a = y;
    x     = x ^ (x << 23);
    gen_b = x ^ y ^ (x >> 17) ^ (y >> 26);
    sum   = gen_b + y;
  endtask

  task automatic rng_respond(input xsrng_pkg::in_word_t req,
                             output xsrng_pkg::out_word_t res);
    logic [WordW-1:0] raw;
    res = '0;
    case (req.func)
      xsrng_pkg::FuncSeed: begin
        seed_gen(req.seed_value);
        n_reseed++;
      end
      xsrng_pkg::FuncRaw: begin
        draw_gen(raw);
        res.value = raw;
        n_raw++;
      end
      xsrng_pkg::FuncBounded: begin
        // empty or inverted range: flag it, leave the generator alone
        if ($signed(cfg_lo) >= $signed(cfg_hi)) begin
          res.status = 1'b1;
          n_reject++;
        end else begin
          draw_gen(raw);
          res.value = cfg_lo + raw % (cfg_hi - cfg_lo);
          n_bounded++;
        end
      end
      default: n_nop++;
    endcase
  endtask

  // Driver: new word at the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= requests_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    xsrng_pkg::out_word_t predicted;
    xsrng_pkg::out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rng_respond(in_data, predicted);
        draws_owed_q.push_back(predicted);
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (draws_owed_q.size() == 0) begin
          $error("result word with nothing owed: value %h status %0d",
                 out_data.value, out_data.status);
          errors++;
        end else begin
          want = draws_owed_q.pop_front();
          if (out_data.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_data.value);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_req(input logic [1:0] func, input logic [WordW-1:0] seed);
    xsrng_pkg::in_word_t w;
    w.func       = func;
    w.seed_value = seed;
    requests_q.push_back(w);
  endtask

  // Sender holds off until every owed result is back. Returns at a falling edge.
  task automatic settle();
    do @(posedge clk);
    while (requests_q.size() != 0 || in_valid || draws_owed_q.size() != 0);
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at one with cfg_valid still high.
  task automatic cfg_write(input logic [1:0] idx, input logic [WordW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      xsrng_pkg::CfgDefaultSeed: cfg_seed = data;
      xsrng_pkg::CfgLowerBound:  cfg_lo   = data;
      default:                   cfg_hi   = data;
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic program_cfg(input logic [WordW-1:0] seed, input logic [WordW-1:0] lo,
                             input logic [WordW-1:0] hi);
    cfg_write(xsrng_pkg::CfgDefaultSeed, seed);
    cfg_write(xsrng_pkg::CfgLowerBound, lo);
    cfg_write(xsrng_pkg::CfgUpperBound, hi);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [WordW-1:0] lo, hi, tmp;
    int unsigned      pick;
    logic [1:0]       func;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling.
    // Inverted range while still unseeded: rejected, no auto-seed. Upper stays
    // at its reset value, default seed too, so the first raw draw seeds from zero.
    cfg_write(xsrng_pkg::CfgLowerBound, 64'd5);
    cfg_valid <= 1'b0;
    push_req(xsrng_pkg::FuncBounded, '0);
    push_req(xsrng_pkg::FuncNop, AllOnes);
    push_req(xsrng_pkg::FuncRaw, '0);
    push_req(xsrng_pkg::FuncBounded, '0);
    settle();

    // Full signed span: range is 2^64 - 1. Reseed with extreme seeds.
    program_cfg(AllOnes, MinS, MaxS);
    push_req(xsrng_pkg::FuncBounded, '0);
    push_req(xsrng_pkg::FuncBounded, AllOnes);
    push_req(xsrng_pkg::FuncSeed, '0);
    push_req(xsrng_pkg::FuncRaw, '0);
    push_req(xsrng_pkg::FuncBounded, '0);
    push_req(xsrng_pkg::FuncSeed, AllOnes);
    push_req(xsrng_pkg::FuncRaw, '0);
    push_req(xsrng_pkg::FuncSeed, MinS);
    push_req(xsrng_pkg::FuncRaw, '0);
    push_req(xsrng_pkg::FuncNop, '0);
    push_req(xsrng_pkg::FuncSeed, MaxS);
    push_req(xsrng_pkg::FuncBounded, '0);
    settle();

    // Range of one at the top of the signed span.
    program_cfg('0, MaxS - 64'd1, MaxS);
    push_req(xsrng_pkg::FuncBounded, '0);
    push_req(xsrng_pkg::FuncRaw, '0);
    settle();

    // lower equal to upper, then lower above upper at the extremes
    program_cfg('0, 64'd7, 64'd7);
    push_req(xsrng_pkg::FuncBounded, '0);
    settle();
    program_cfg('0, MaxS, MinS);
    push_req(xsrng_pkg::FuncBounded, '0);
    settle();

    // Range straddling zero.
    program_cfg('0, -64'sd5, 64'd3);
    push_req(xsrng_pkg::FuncBounded, '0);
    push_req(xsrng_pkg::FuncBounded, '0);
    push_req(xsrng_pkg::FuncBounded, '0);
    settle();

    // Random phases. Each one drains before the registers change, which also
    // serves as a full hold-off of the sender.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase

      case (p)
        0: begin lo = MinS;        hi = MaxS;     end
        1: begin lo = -64'sd100;   hi = 64'd100;  end
        2: begin lo = '0;          hi = 64'd2;    end
        3: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
          if ($signed(lo) > $signed(hi)) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
        4: begin lo = 64'd42;      hi = 64'd42;   end
        5: begin lo = MaxS;        hi = MinS;     end
        6: begin lo = MinS;        hi = '0;       end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase

      case (p % 3)
        0: tmp = '0;
        1: tmp = AllOnes;
        default: tmp = {$urandom, $urandom};
      endcase
      program_cfg(tmp, lo, hi);

      for (int unsigned i = 0; i < PhaseWords; i++) begin
        pick = $urandom_range(99);
        if (pick < 8) func = xsrng_pkg::FuncSeed;
        else if (pick < 48) func = xsrng_pkg::FuncRaw;
        else if (pick < 93) func = xsrng_pkg::FuncBounded;
        else func = xsrng_pkg::FuncNop;
        case ($urandom_range(9))
          0: tmp = '0;
          1: tmp = AllOnes;
          default: tmp = {$urandom, $urandom};
        endcase
        push_req(func, tmp);
      end
      settle();
    end

    // let any stray result show up
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d reseeds, %0d raw draws, %0d bounded draws, %0d rejected, %0d nops",
             n_reseed, n_raw, n_bounded, n_reject, n_nop);
    $display("%0d register writes over 6 directed groups and %0d idle/stall phases",
             n_cfg, NumPhases);
    if (errors == 0) begin
      $display("xorshift128plus_bounded_rng_core: match");
    end else begin
      $display("xorshift128plus_bounded_rng_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("timeout with %0d words still owed", draws_owed_q.size());
    $display("xorshift128plus_bounded_rng_core: mismatch");
    $finish;
  end

endmodule
